// ===== hdl/sca_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sine/cosine sample to angle encoder.
// Holds shared constants, the CORDIC arctangent table and the control types.
package sca_pkg;

   localparam int SAMPLE_PORT_BITS = 8;
   localparam int ANGLE_PORT_BITS = 16;

   localparam int SAMPLE_BITS_DEFAULT = 8;
   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int CORDIC_STEPS_DEFAULT = 16;

   localparam int MAX_STEPS = 24;
   localparam int STEP_BITS = $clog2(MAX_STEPS);
   localparam int GUARD_BITS = 24;
   localparam int TURN_BITS = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TURN_BITS-1:0] ZERO_TURN = 32'h0000_0000;
   localparam logic [TURN_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [TURN_BITS-1:0] HALF_TURN = 32'h8000_0000;
   localparam logic [TURN_BITS-1:0] NEG_QUARTER_TURN = 32'hC000_0000;

   typedef enum logic {
      CHANNEL_COSINE,
      CHANNEL_SINE
   } channel_type;

   typedef enum logic [1:0] {
      CORDIC_IDLE,
      CORDIC_ROTATE,
      CORDIC_FINISH
   } cordic_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [TURN_BITS-1:0] atan_turn(input logic [STEP_BITS-1:0] idx);
      logic [TURN_BITS-1:0] val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         default: val = ZERO_TURN;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/sincos_sample_to_angle.sv =====
`timescale 1ns / 1ps
// Sine/cosine sample to angle encoder, top level.
// Depends on sca_pkg, sca_front, sca_queue and sca_cordic.
//
// Samples arrive alternately on the cosine and then the sine channel; every
// transaction returns atan2(sine, cosine) of the latest two values with mid-scale
// removed, as a binary angle where half scale is pi. The front end takes a sample
// into a two-entry queue while the queue is not full; the iterative CORDIC unit
// behind it, which skips the rotation steps when a value lies on an axis, works on
// one sample at a time and so sets the sustained rate. A finished angle waits in
// an output register while the next sample is already in work.
module sincos_sample_to_angle
   import sca_pkg::*;
#(
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEFAULT,
   parameter int ANGLE_BITS   = ANGLE_BITS_DEFAULT,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [SAMPLE_PORT_BITS-1:0] req_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ANGLE_PORT_BITS-1:0]  rsp_angle,
   output logic                        rsp_updated_sine
);

   localparam int ENTRY_BITS = 2 * (SAMPLE_BITS + 1) + 1;

   queue_status_type      queue_status;
   logic                  push_valid;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop;
   logic [ENTRY_BITS-1:0] pop_data;

   sca_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   sca_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .status     (queue_status)
   );

   sca_cordic #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock            (clock),
      .reset            (reset),
      .queue_status     (queue_status),
      .pop_data         (pop_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_angle        (rsp_angle),
      .rsp_updated_sine (rsp_updated_sine)
   );

endmodule

// ===== hdl/sca_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples, tracks the channel order and keeps the latest values.
// Pushes offset-free cosine and sine into the queue. Depends on sca_pkg.
module sca_front
   import sca_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [SAMPLE_PORT_BITS-1:0]   req_sample,
   input  queue_status_type              queue_status,
   output logic                          push_valid,
   output logic [2*(SAMPLE_BITS+1):0]    push_data
);

   localparam logic [SAMPLE_BITS:0] OFFSET = (SAMPLE_BITS + 1)'(1) << (SAMPLE_BITS - 1);

   channel_type            next_channel_ff, next_channel_in;
   logic [SAMPLE_BITS-1:0] cosine_ff, cosine_in;
   logic [SAMPLE_BITS-1:0] sine_ff, sine_in;
   logic [SAMPLE_BITS-1:0] value;
   logic [SAMPLE_BITS:0]   cos_centered;
   logic [SAMPLE_BITS:0]   sin_centered;
   logic                   accept;

   assign req_stall = queue_status.full;
   assign accept = req_valid && !queue_status.full;
   assign push_valid = accept;
   assign value = SAMPLE_BITS'(req_sample);

   always_comb begin
      next_channel_in = next_channel_ff;
      cosine_in = cosine_ff;
      sine_in = sine_ff;
      if (accept) begin
         if (next_channel_ff == CHANNEL_COSINE) begin
            cosine_in = value;
            next_channel_in = CHANNEL_SINE;
         end else begin
            sine_in = value;
            next_channel_in = CHANNEL_COSINE;
         end
      end
   end

   assign cos_centered = {1'b0, cosine_in} - OFFSET;
   assign sin_centered = {1'b0, sine_in} - OFFSET;
   assign push_data = {(next_channel_ff == CHANNEL_SINE), sin_centered, cos_centered};

   always_ff @(posedge clock) begin
      if (reset) begin
         next_channel_ff <= CHANNEL_COSINE;
         cosine_ff <= '0;
         sine_ff <= '0;
      end else begin
         next_channel_ff <= next_channel_in;
         cosine_ff <= cosine_in;
         sine_ff <= sine_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_channel_toggles: assert property (@(posedge clock) disable iff (reset)
      accept |=> (next_channel_ff != $past(next_channel_ff)))
      else $error("channel did not toggle after a transaction");
`endif

endmodule

// ===== hdl/sca_queue.sv =====
`timescale 1ns / 1ps
// Short queue between the front end and the CORDIC unit.
// Depends on sca_pkg for its depth and status type.
module sca_queue
   import sca_pkg::*;
#(
   parameter int DATA_BITS = 2 * (SAMPLE_BITS_DEFAULT + 1) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output queue_status_type     status
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0]  entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign status.full = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push_valid)
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("pop from an empty queue");
`endif

endmodule

// ===== hdl/sca_cordic.sv =====
`timescale 1ns / 1ps
// Back end: iterative CORDIC in vectoring mode with a registered result stage.
// Depends on sca_pkg for the arctangent table, constants and state type.
module sca_cordic
   import sca_pkg::*;
#(
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEFAULT,
   parameter int ANGLE_BITS   = ANGLE_BITS_DEFAULT,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  queue_status_type             queue_status,
   input  logic [2*(SAMPLE_BITS+1):0]   pop_data,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ANGLE_PORT_BITS-1:0]   rsp_angle,
   output logic                         rsp_updated_sine
);

   localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
   localparam int W = SAMPLE_BITS + GUARD_BITS + 3;
   localparam logic [TURN_BITS-1:0] ROUND_ADD = TURN_BITS'(1) << (TURN_BITS - 1 - ANGLE_BITS);

   cordic_state_type           state_ff, state_in;
   logic signed [W-1:0]        x_ff, x_in;
   logic signed [W-1:0]        y_ff, y_in;
   logic [TURN_BITS-1:0]       acc_ff, acc_in;
   logic [STEP_BITS-1:0]       step_ff, step_in;
   logic                       updated_ff, updated_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_PORT_BITS-1:0] rsp_angle_ff, rsp_angle_in;
   logic                       rsp_updated_sine_ff, rsp_updated_sine_in;

   logic signed [SAMPLE_BITS:0] x_q, y_q;
   logic signed [W-1:0]         x_ext, y_ext;
   logic                        special;
   logic [TURN_BITS-1:0]        special_turn;
   logic signed [W-1:0]         dx, dy;
   logic                        last_step;
   logic                        out_free;
   logic                        load_result;
   logic [TURN_BITS-1:0]        rounded_sum;
   logic [TURN_BITS-1:0]        rounded;

   assign x_q = signed'(pop_data[SAMPLE_BITS:0]);
   assign y_q = signed'(pop_data[2*SAMPLE_BITS+1:SAMPLE_BITS+1]);
   assign x_ext = W'(x_q);
   assign y_ext = W'(y_q);

   always_comb begin
      special = 1'b1;
      special_turn = ZERO_TURN;
      if (x_q == '0 && y_q == '0) begin
         special_turn = ZERO_TURN;
      end else if (y_q == '0) begin
         special_turn = x_q[SAMPLE_BITS] ? HALF_TURN : ZERO_TURN;
      end else if (x_q == '0) begin
         special_turn = y_q[SAMPLE_BITS] ? NEG_QUARTER_TURN : QUARTER_TURN;
      end else begin
         special = 1'b0;
      end
   end

   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign last_step = (step_ff == STEP_BITS'(STEPS - 1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CORDIC_IDLE: begin
            if (!queue_status.empty) begin
               state_in = special ? CORDIC_FINISH : CORDIC_ROTATE;
            end
         end
         CORDIC_ROTATE: begin
            if (last_step) begin
               state_in = CORDIC_FINISH;
            end
         end
         CORDIC_FINISH: begin
            if (out_free) begin
               state_in = CORDIC_IDLE;
            end
         end
         default: state_in = CORDIC_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop = 1'b0;
      load_result = 1'b0;
      case (state_ff)
         CORDIC_IDLE:   pop = !queue_status.empty;
         CORDIC_ROTATE: pop = 1'b0;
         CORDIC_FINISH: load_result = out_free;
         default: begin
            pop = 1'b0;
            load_result = 1'b0;
         end
      endcase
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      updated_in = updated_ff;
      if (pop) begin
         updated_in = pop_data[2*SAMPLE_BITS+2];
         step_in = '0;
         if (special) begin
            acc_in = special_turn;
         end else if (x_q[SAMPLE_BITS]) begin
            x_in = (-x_ext) <<< GUARD_BITS;
            y_in = (-y_ext) <<< GUARD_BITS;
            acc_in = HALF_TURN;
         end else begin
            x_in = x_ext <<< GUARD_BITS;
            y_in = y_ext <<< GUARD_BITS;
            acc_in = ZERO_TURN;
         end
      end else if (state_ff == CORDIC_ROTATE) begin
         step_in = step_ff + 1'b1;
         if (!y_ff[W-1]) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            acc_in = acc_ff + atan_turn(step_ff);
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            acc_in = acc_ff - atan_turn(step_ff);
         end
      end
   end

   assign rounded_sum = acc_ff + ROUND_ADD;
   assign rounded = rounded_sum >> (TURN_BITS - ANGLE_BITS);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_updated_sine_in = rsp_updated_sine_ff;
      if (load_result) begin
         rsp_valid_in = 1'b1;
         rsp_angle_in = rounded[ANGLE_PORT_BITS-1:0];
         rsp_updated_sine_in = updated_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORDIC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      step_ff <= step_in;
      updated_ff <= updated_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_updated_sine_ff <= rsp_updated_sine_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = rsp_angle_ff;
   assign rsp_updated_sine = rsp_updated_sine_ff;

`ifndef NO_ASSERTIONS
   a_x_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CORDIC_ROTATE) |-> !x_ff[W-1])
      else $error("x went negative during rotation");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CORDIC_ROTATE) |-> (step_ff < STEP_BITS'(STEPS)))
      else $error("step count beyond the last iteration");
`endif

endmodule
